// ===== rtl/bellman_choice_argmax_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the choice argmax block
// Shared concurrent assertion forms, clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef BELLMAN_CHOICE_ARGMAX_MACROS_SVH
`define BELLMAN_CHOICE_ARGMAX_MACROS_SVH

// Implication checked outside of reset
`define BCA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside of reset
`define BCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds through reset
`define BCA_ASSERT_NEXT_NR(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bca_pkg.sv =====
// ----------------------------------------------------------------------------
// bca_pkg
// Types, constants and saturation helpers for the choice argmax block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bca_pkg;

   // Q16.16 value width and result index width
   localparam int VAL_W       = 32;
   localparam int OUT_IDX_W   = 12;
   localparam int FRAC_W      = 16;

   // Candidate limit per state; the running count stops at MAX_CHOICES - 1
   localparam int MAX_CHOICES = 4096;
   localparam int CNT_W       = $clog2(MAX_CHOICES);

   // Queue between front and back
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   // Widths of the wide intermediate sums
   localparam int PROD_W      = 2 * VAL_W;
   localparam int SUM_W       = PROD_W - FRAC_W + 2;

   // Stream payload widths
   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 48;

   // Configuration register indexes
   localparam int CSR_ADDR_W  = 2;
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_FIXED_COST = 2'd0,
      REG_NEG_SLOPE  = 2'd1,
      REG_POS_SLOPE  = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic                  we;
      logic [CSR_ADDR_W-1:0] addr;
      logic [VAL_W-1:0]      wdata;
   } csr_type;

   // Classified candidate handed from front to back
   typedef struct packed {
      logic signed [VAL_W-1:0] payoff;     // saturated wealth - cost
      logic signed [VAL_W-1:0] slope;      // slope picked by payoff sign
      logic signed [VAL_W-1:0] fixed;      // fixed cost, zero for non-negative payoff
      logic signed [VAL_W-1:0] future;     // continuation value
      logic                    last;
   } work_type;

   // Clamp a wide signed sum to the Q16.16 range
   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'({1'b0, {(VAL_W-1){1'b1}}});
      lo = -hi - SUM_W'(1);
      if (v > hi) begin
         sat_val = {1'b0, {(VAL_W-1){1'b1}}};
      end else if (v < lo) begin
         sat_val = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         sat_val = v[VAL_W-1:0];
      end
   endfunction

endpackage

// ===== rtl/bca_fifo.sv =====
// ----------------------------------------------------------------------------
// bca_fifo
// Short queue of classified candidates between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bca_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  bca_pkg::work_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output bca_pkg::work_type pop_data
);

   bca_pkg::work_type                      mem_ff [bca_pkg::FIFO_DEPTH];
   logic [bca_pkg::FIFO_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [bca_pkg::FIFO_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [bca_pkg::FIFO_CNT_W-1:0]         count_ff, count_in;
   logic                                   do_push;
   logic                                   do_pop;

   assign push_ready = (count_ff != bca_pkg::FIFO_CNT_W'(bca_pkg::FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/bca_front.sv =====
// ----------------------------------------------------------------------------
// bca_front
// Accepts candidates, forms the saturated payoff and picks its cost terms.
// Holds the configuration registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bca_front (
   input  logic                          clock,
   input  logic                          reset,
   input  bca_pkg::csr_type              csr,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [bca_pkg::VAL_W-1:0] wealth,
   input  logic signed [bca_pkg::VAL_W-1:0] cost,
   input  logic signed [bca_pkg::VAL_W-1:0] future_value,
   input  logic                          last_candidate,
   output logic                          push_valid,
   input  logic                          push_ready,
   output bca_pkg::work_type             push_data
);

   logic signed [bca_pkg::VAL_W-1:0] fixed_cost_ff, fixed_cost_in;
   logic signed [bca_pkg::VAL_W-1:0] neg_slope_ff, neg_slope_in;
   logic signed [bca_pkg::VAL_W-1:0] pos_slope_ff, pos_slope_in;
   logic                             valid_ff, valid_in;
   bca_pkg::work_type                work_ff, work_in;
   logic signed [bca_pkg::SUM_W-1:0] diff;
   logic signed [bca_pkg::VAL_W-1:0] payoff;
   logic                             accept;

   // Decode configuration writes
   always_comb begin
      fixed_cost_in = fixed_cost_ff;
      neg_slope_in  = neg_slope_ff;
      pos_slope_in  = pos_slope_ff;
      if (csr.we) begin
         case (bca_pkg::reg_index_type'(csr.addr))
            bca_pkg::REG_FIXED_COST: fixed_cost_in = csr.wdata;
            bca_pkg::REG_NEG_SLOPE:  neg_slope_in  = csr.wdata;
            bca_pkg::REG_POS_SLOPE:  pos_slope_in  = csr.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fixed_cost_ff <= '0;
         neg_slope_ff  <= '0;
         pos_slope_ff  <= '0;
      end else begin
         fixed_cost_ff <= fixed_cost_in;
         neg_slope_ff  <= neg_slope_in;
         pos_slope_ff  <= pos_slope_in;
      end
   end

   // Take a transaction whenever the holding register is free or draining
   assign in_ready   = !valid_ff || push_ready;
   assign accept     = in_valid && in_ready;
   assign push_valid = valid_ff;
   assign push_data  = work_ff;

   // Classify: saturated payoff, then cost terms by its sign
   always_comb begin
      diff           = bca_pkg::SUM_W'(wealth) - bca_pkg::SUM_W'(cost);
      payoff         = bca_pkg::sat_val(diff);
      work_in.payoff = payoff;
      work_in.slope  = payoff[bca_pkg::VAL_W-1] ? neg_slope_ff : pos_slope_ff;
      work_in.fixed  = payoff[bca_pkg::VAL_W-1] ? fixed_cost_ff : '0;
      work_in.future = future_value;
      work_in.last   = last_candidate;
      valid_in       = accept ? 1'b1 : (push_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         work_ff <= work_in;
      end
   end

endmodule

// ===== rtl/bca_back.sv =====
// ----------------------------------------------------------------------------
// bca_back
// Applies the slope product, adds the continuation value and tracks the
// running maximum; loads the result register on the last candidate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bca_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  bca_pkg::work_type                 pop_data,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [bca_pkg::OUT_IDX_W-1:0]     best_index,
   output logic signed [bca_pkg::VAL_W-1:0]  best_value
);

   logic                                   advance;

   // Product stage
   logic                                   s1_valid_ff, s1_valid_in;
   logic signed [bca_pkg::PROD_W-1:0]      s1_prod_ff;
   logic signed [bca_pkg::VAL_W-1:0]       s1_payoff_ff;
   logic signed [bca_pkg::VAL_W-1:0]       s1_fixed_ff;
   logic signed [bca_pkg::VAL_W-1:0]       s1_future_ff;
   logic                                   s1_last_ff;

   // Payment stage
   logic                                   s2_valid_ff, s2_valid_in;
   logic signed [bca_pkg::VAL_W-1:0]       s2_pay_ff;
   logic signed [bca_pkg::VAL_W-1:0]       s2_future_ff;
   logic                                   s2_last_ff;
   logic signed [bca_pkg::SUM_W-1:0]       prod_term;
   logic signed [bca_pkg::SUM_W-1:0]       pay_sum;

   // Running maximum state
   logic signed [bca_pkg::VAL_W-1:0]       best_ff, best_in;
   logic [bca_pkg::CNT_W-1:0]              index_ff, index_in;
   logic [bca_pkg::CNT_W-1:0]              count_ff, count_in;
   logic signed [bca_pkg::SUM_W-1:0]       value_sum;
   logic signed [bca_pkg::VAL_W-1:0]       value;
   logic signed [bca_pkg::VAL_W-1:0]       cand_best;
   logic [bca_pkg::CNT_W-1:0]              cand_index;

   // Result register
   logic                                   out_valid_ff, out_valid_in;
   logic [bca_pkg::OUT_IDX_W-1:0]          out_index_ff;
   logic signed [bca_pkg::VAL_W-1:0]       out_value_ff;

   // Stall the whole back pipeline only while a result waits unread
   assign advance   = !out_valid_ff || out_ready;
   assign pop_ready = advance;

   assign s1_valid_in = advance ? pop_valid   : s1_valid_ff;
   assign s2_valid_in = advance ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Multiply slope by payoff
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_prod_ff   <= pop_data.slope * pop_data.payoff;
         s1_payoff_ff <= pop_data.payoff;
         s1_fixed_ff  <= pop_data.fixed;
         s1_future_ff <= pop_data.future;
         s1_last_ff   <= pop_data.last;
      end
   end

   // Payment: add floor(product / 2^16) for a loss, subtract it for a gain
   assign prod_term = bca_pkg::SUM_W'($signed(s1_prod_ff[bca_pkg::PROD_W-1:bca_pkg::FRAC_W]));
   assign pay_sum   = bca_pkg::SUM_W'(s1_payoff_ff) - bca_pkg::SUM_W'(s1_fixed_ff)
                    + (s1_payoff_ff[bca_pkg::VAL_W-1] ? prod_term : -prod_term);

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_pay_ff    <= bca_pkg::sat_val(pay_sum);
         s2_future_ff <= s1_future_ff;
         s2_last_ff   <= s1_last_ff;
      end
   end

   // Add continuation value and compare with the running best
   always_comb begin
      value_sum = bca_pkg::SUM_W'(s2_pay_ff) + bca_pkg::SUM_W'(s2_future_ff);
      value     = bca_pkg::sat_val(value_sum);
      if (count_ff == '0) begin
         cand_best  = value;
         cand_index = '0;
      end else if (value > best_ff) begin
         cand_best  = value;
         cand_index = count_ff;
      end else begin
         cand_best  = best_ff;
         cand_index = index_ff;
      end

      best_in      = best_ff;
      index_in     = index_ff;
      count_in     = count_ff;
      out_valid_in = advance ? 1'b0 : out_valid_ff;
      if (advance && s2_valid_ff) begin
         if (s2_last_ff) begin
            // Close the state and start over
            best_in      = '0;
            index_in     = '0;
            count_in     = '0;
            out_valid_in = 1'b1;
         end else begin
            best_in  = cand_best;
            index_in = cand_index;
            if (count_ff != bca_pkg::CNT_W'(bca_pkg::MAX_CHOICES - 1)) begin
               count_in = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff      <= '0;
         index_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         best_ff      <= best_in;
         index_ff     <= index_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Load the result on the last candidate
   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff && s2_last_ff) begin
         out_index_ff <= bca_pkg::OUT_IDX_W'(cand_index);
         out_value_ff <= cand_best;
      end
   end

   assign out_valid  = out_valid_ff;
   assign best_index = out_index_ff;
   assign best_value = out_value_ff;

endmodule

// ===== rtl/bellman_choice_argmax.sv =====
// Path to rsp_: front holding register, queue, product stage, payment stage, result register.
// Throughput: one candidate per cycle; every stage takes a new candidate each cycle unless stalled.
// The back pipeline stalls only while a result waits unread on rsp_.
// Reset: synchronous, active high; clears the configuration registers to zero, the running state and
// the candidate queue, and drops rsp_tvalid.
// ----------------------------------------------------------------------------
// bellman_choice_argmax
// Best-choice search for one state over a stream of candidate choices.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bellman_choice_argmax (
   input  logic                               clock,
   input  logic                               reset,
   // Configuration write port
   input  logic                               csr_we,
   input  logic [bca_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [bca_pkg::VAL_W-1:0]          csr_wdata,
   // Candidate stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bca_pkg::REQ_DATA_W-1:0]     req_tdata,   // wealth, cost, future_value
   input  logic                               req_tlast,   // last_candidate
   // Result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bca_pkg::RSP_DATA_W-1:0]     rsp_tdata    // best_index, best_value, zero fill
);

   bca_pkg::csr_type                  csr;
   logic                              push_valid;
   logic                              push_ready;
   bca_pkg::work_type                 push_data;
   logic                              pop_valid;
   logic                              pop_ready;
   bca_pkg::work_type                 pop_data;
   logic [bca_pkg::OUT_IDX_W-1:0]     best_index;
   logic signed [bca_pkg::VAL_W-1:0]  best_value;

   assign csr.we    = csr_we;
   assign csr.addr  = csr_addr;
   assign csr.wdata = csr_wdata;

   // Front: accept and classify
   bca_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr            (csr),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .wealth         (req_tdata[31:0]),
      .cost           (req_tdata[63:32]),
      .future_value   (req_tdata[95:64]),
      .last_candidate (req_tlast),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   // Queue between front and back
   bca_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Back: evaluate and track the maximum
   bca_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .best_index (best_index),
      .best_value (best_value)
   );

   assign rsp_tdata = {4'b0000, best_value, best_index};

endmodule

// ===== rtl/bca_checker.sv =====
// ----------------------------------------------------------------------------
// bca_checker
// Port-level checks on the result stream of the choice argmax block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bellman_choice_argmax_macros.svh"

module bca_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [bca_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled result transaction holds
   `BCA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // Fill bits above the value stay zero
   `BCA_ASSERT_IMPL(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[47:44] == 4'b0000, "result fill bits not zero")

   // Reset drops any pending result
   `BCA_ASSERT_NEXT_NR(a_rst_clear, clock, reset, !rsp_tvalid, "result valid after reset")

   // No result comes out right after reset release
   `BCA_ASSERT_IMPL(a_rst_latency, clock, 1'b0, $fell(reset), !rsp_tvalid ##1 !rsp_tvalid, "result too early after reset")

   // The input side is ready in the cycle after a reset cycle
   `BCA_ASSERT_NEXT_NR(a_rst_ready, clock, reset && req_tvalid, req_tready, "input not ready after reset")

endmodule

bind bellman_choice_argmax bca_checker u_bca_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
